### design/ssg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, constants and tables for the spatial source gain block.
// ----------------------------------------------------------------------------
package ssg_pkg;

    // Field widths.
    localparam int CW   = 24;          // coordinate width, Q15.8
    localparam int DW   = 25;          // coordinate difference width
    localparam int SW   = 50;          // sum of squares width
    localparam int VW   = 16;          // volume width, Q4.12
    localparam int MW   = 24;          // max distance width, Q16.8
    localparam int GW   = 16;          // gain width, Q1.15
    localparam int LW   = 16;          // level difference / angle width
    localparam int XW   = 28;          // CORDIC vector width
    localparam int RTW  = 26;          // square root width
    localparam int RMW  = 29;          // square root remainder width
    localparam int NW   = 31;          // division numerator width
    localparam int QW   = 16;          // division quotient width
    localparam int CNTW = 4;           // sequencer counter width
    localparam int IW   = 2;           // configuration index width

    // Sequencer lengths.
    localparam int CORDIC_STEPS = 14;
    localparam int ROOT_CYCLES  = 13;  // two root bits per cycle
    localparam int DIV_CYCLES   = 8;   // two quotient bits per cycle

    // Arithmetic constants.
    localparam logic [GW-1:0]   GAIN_ONE  = 16'd32768;
    localparam logic signed [LW-1:0] LD_POS = 16'sd16384;
    localparam logic signed [LW-1:0] LD_NEG = -16'sd16384;
    localparam logic [RTW-1:0]  DEN_BIAS  = 26'd2560;
    localparam logic [NW-1:0]   NUM_SCALE = 31'd20480;
    localparam logic [22:0]     AUD_SCALE = 23'd125;

    // Configuration register indexes.
    localparam logic [IW-1:0] REG_LISTENER_X = 2'd0;
    localparam logic [IW-1:0] REG_LISTENER_Y = 2'd1;
    localparam logic [IW-1:0] REG_LISTENER_Z = 2'd2;

    // One classified source waiting for the back end.
    typedef struct packed {
        logic [SW-1:0]          sum_sq;
        logic                   in_range;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dz;
        logic [VW-1:0]          volume;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_DIV,
        ST_GAIN,
        ST_DONE
    } t_state;

    // Arctangent table in units of pi/32768.
    function automatic logic signed [LW-1:0] atan_entry(input logic [CNTW-1:0] idx);
        logic signed [LW-1:0] v;
        case (idx)
            4'd0:    v = 16'sd8192;
            4'd1:    v = 16'sd4836;
            4'd2:    v = 16'sd2555;
            4'd3:    v = 16'sd1297;
            4'd4:    v = 16'sd651;
            4'd5:    v = 16'sd326;
            4'd6:    v = 16'sd163;
            4'd7:    v = 16'sd81;
            4'd8:    v = 16'sd41;
            4'd9:    v = 16'sd20;
            4'd10:   v = 16'sd10;
            4'd11:   v = 16'sd5;
            4'd12:   v = 16'sd3;
            4'd13:   v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/spatial_source_gain.sv
`default_nettype none
// Path from an accepted source to its result: 2 front stages, the queue, the
// root/angle steps, the divide steps, the gain product and the output register.
// The back-end sequencer takes a new source only after the last one is done
// (shared square root, CORDIC and divider); the queue holds 4 sources ahead.
// Reset: synchronous, active low; clears the listener position, queue and
// sequencer. No clearing pass; the block accepts sources the cycle after reset.
// ----------------------------------------------------------------------------
// spatial_source_gain
// Distance attenuation and azimuth panning gains for one sound source.
// ----------------------------------------------------------------------------
module spatial_source_gain #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [ssg_pkg::CW-1:0]     i_source_x,
    input  wire logic [ssg_pkg::CW-1:0]     i_source_y,
    input  wire logic [ssg_pkg::CW-1:0]     i_source_z,
    input  wire logic [ssg_pkg::VW-1:0]     i_source_volume,
    input  wire logic [ssg_pkg::MW-1:0]     i_max_distance,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [ssg_pkg::GW-1:0]          o_left_gain,
    output logic [ssg_pkg::GW-1:0]          o_right_gain,
    output logic                            o_audible,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [ssg_pkg::IW-1:0]     i_cfg_index,
    input  wire logic [ssg_pkg::CW-1:0]     i_cfg_data
);
    import ssg_pkg::*;

    logic [CW-1:0]  r_listener_x, r_listener_y, r_listener_z;
    logic           w_push, w_pop, w_job_valid;
    t_job           w_push_job, w_pop_job;

    // Listener position registers; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listener_x <= '0;
            r_listener_y <= '0;
            r_listener_z <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LISTENER_X: r_listener_x <= i_cfg_data;
                REG_LISTENER_Y: r_listener_y <= i_cfg_data;
                REG_LISTENER_Z: r_listener_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ssg_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_source_x      (i_source_x),
        .i_source_y      (i_source_y),
        .i_source_z      (i_source_z),
        .i_source_volume (i_source_volume),
        .i_max_distance  (i_max_distance),
        .i_listener_x    (r_listener_x),
        .i_listener_y    (r_listener_y),
        .i_listener_z    (r_listener_z),
        .i_pop           (w_pop),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    ssg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_pop_job)
    );

    ssg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_job        (w_pop_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_gain  (o_left_gain),
        .o_right_gain (o_right_gain),
        .o_audible    (o_audible)
    );

endmodule
`default_nettype wire

### design/ssg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssg_front
// Accepts sources, forms offsets to the listener, squares them and classifies
// the source as in or out of range before pushing it into the queue.
// ----------------------------------------------------------------------------
module ssg_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [ssg_pkg::CW-1:0]       i_source_x,
    input  wire logic [ssg_pkg::CW-1:0]       i_source_y,
    input  wire logic [ssg_pkg::CW-1:0]       i_source_z,
    input  wire logic [ssg_pkg::VW-1:0]       i_source_volume,
    input  wire logic [ssg_pkg::MW-1:0]       i_max_distance,
    input  wire logic [ssg_pkg::CW-1:0]       i_listener_x,
    input  wire logic [ssg_pkg::CW-1:0]       i_listener_y,
    input  wire logic [ssg_pkg::CW-1:0]       i_listener_z,
    input  wire logic                         i_pop,
    output logic                              o_push,
    output ssg_pkg::t_job                     o_job
);
    import ssg_pkg::*;

    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    logic [OW-1:0]          r_occ, n_occ;
    logic                   w_accept;

    logic                   r_a_valid;
    logic signed [DW-1:0]   r_a_dx, r_a_dy, r_a_dz;
    logic [VW-1:0]          r_a_vol;
    logic [MW-1:0]          r_a_maxd;

    logic                   r_b_valid;
    logic [SW-1:0]          r_b_sqx, r_b_sqy, r_b_sqz;
    logic [2*MW-1:0]        r_b_maxsq;
    logic signed [DW-1:0]   r_b_dx, r_b_dz;
    logic [VW-1:0]          r_b_vol;

    logic signed [SW-1:0]   w_px, w_py, w_pz;
    logic [2*MW-1:0]        w_mq;
    logic [SW-1:0]          w_sum;

    // Credits cover items in both front stages and in the queue.
    assign o_stall  = (r_occ == OW'(QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_occ = r_occ;
        if (w_accept && !i_pop) begin
            n_occ = r_occ + OW'(1);
        end else if (!w_accept && i_pop) begin
            n_occ = r_occ - OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_occ     <= n_occ;
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage A: offsets from the listener.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_dx   <= $signed({i_source_x[CW-1], i_source_x})
                      - $signed({i_listener_x[CW-1], i_listener_x});
            r_a_dy   <= $signed({i_source_y[CW-1], i_source_y})
                      - $signed({i_listener_y[CW-1], i_listener_y});
            r_a_dz   <= $signed({i_source_z[CW-1], i_source_z})
                      - $signed({i_listener_z[CW-1], i_listener_z});
            r_a_vol  <= i_source_volume;
            r_a_maxd <= i_max_distance;
        end
    end

    // Stage B: squares of the offsets and of the range limit.
    assign w_px = r_a_dx * r_a_dx;
    assign w_py = r_a_dy * r_a_dy;
    assign w_pz = r_a_dz * r_a_dz;
    assign w_mq = r_a_maxd * r_a_maxd;

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_sqx   <= unsigned'(w_px);
            r_b_sqy   <= unsigned'(w_py);
            r_b_sqz   <= unsigned'(w_pz);
            r_b_maxsq <= w_mq;
            r_b_dx    <= r_a_dx;
            r_b_dz    <= r_a_dz;
            r_b_vol   <= r_a_vol;
        end
    end

    // Classification and push into the queue.
    assign w_sum = r_b_sqx + r_b_sqy + r_b_sqz;

    assign o_push          = r_b_valid;
    assign o_job.sum_sq    = w_sum;
    assign o_job.in_range  = (w_sum < {{(SW-2*MW){1'b0}}, r_b_maxsq});
    assign o_job.dx        = r_b_dx;
    assign o_job.dz        = r_b_dz;
    assign o_job.volume    = r_b_vol;

endmodule
`default_nettype wire

### design/ssg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssg_queue
// Short first-in first-out queue of classified sources between front and back.
// ----------------------------------------------------------------------------
module ssg_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ssg_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output logic                o_valid,
    output ssg_pkg::t_job       o_job
);
    import ssg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [AW-1:0]      r_wr, r_rd;
    logic [CNW-1:0]     r_count;

    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNW'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNW'(DEPTH)) |-> (!i_push || i_pop))
        else $error("queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");

endmodule
`default_nettype wire

### design/ssg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssg_back
// Works one source at a time: square root and CORDIC angle side by side, then
// the attenuation divide, then the two gain products into the output register.
// ----------------------------------------------------------------------------
module ssg_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_job_valid,
    input  wire ssg_pkg::t_job              i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [ssg_pkg::GW-1:0]          o_left_gain,
    output logic [ssg_pkg::GW-1:0]          o_right_gain,
    output logic                            o_audible
);
    import ssg_pkg::*;

    t_state                 r_state, n_state;
    logic [CNTW-1:0]        r_cnt, n_cnt;

    // Job fields.
    logic                   r_in_range;
    logic [VW-1:0]          r_vol;
    logic [NW-1:0]          r_num;
    logic                   r_dz_pos, r_dz_zero, r_dx_neg, r_dx_zero;

    // Square root.
    logic [2*RTW-1:0]       r_rad;
    logic [RMW-1:0]         r_rrem;
    logic [RTW-1:0]         r_root;

    // CORDIC.
    logic signed [XW-1:0]   r_cx, r_cy;
    logic signed [LW-1:0]   r_cz;
    logic signed [LW-1:0]   r_ld;

    // Divide.
    logic [RTW-1:0]         r_den;
    logic [RTW-1:0]         r_drem;
    logic [QW-1:0]          r_dlow;
    logic [QW-1:0]          r_quo;
    logic                   r_sat;
    logic                   r_aud;

    // Gain products.
    logic [2*GW-1:0]        r_lprod, r_rprod;

    // Output register.
    logic                   r_out_valid;
    logic [GW-1:0]          r_out_left, r_out_right;
    logic                   r_out_aud;

    logic                   w_out_free;

    logic [RMW-1:0]         w_rem0, w_rem1, w_tr0, w_tr1, w_rem_a, w_rem_b;
    logic                   w_ge0, w_ge1;
    logic [RTW-1:0]         w_root_a, w_root_b;

    logic signed [XW-1:0]   w_xs, w_ys;
    logic signed [LW-1:0]   w_atan;

    logic [RTW-1:0]         w_den;
    logic [NW-1:0]          w_num;

    logic [RTW:0]           w_dt0, w_dt1;
    logic                   w_dge0, w_dge1;
    logic [RTW-1:0]         w_drem_a, w_drem_b;

    logic signed [LW-1:0]   w_ld;
    logic [GW-1:0]          w_att, w_lside, w_rside;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_num      = NW'({{(NW-VW){1'b0}}, i_job.volume} * NUM_SCALE);

    // Two square root digits per cycle.
    always_comb begin
        w_rem0   = {r_rrem[RMW-3:0], r_rad[2*RTW-1 -: 2]};
        w_tr0    = {1'b0, r_root, 2'b01};
        w_ge0    = (w_rem0 >= w_tr0);
        w_rem_a  = w_ge0 ? (w_rem0 - w_tr0) : w_rem0;
        w_root_a = {r_root[RTW-2:0], w_ge0};
        w_rem1   = {w_rem_a[RMW-3:0], r_rad[2*RTW-3 -: 2]};
        w_tr1    = {1'b0, w_root_a, 2'b01};
        w_ge1    = (w_rem1 >= w_tr1);
        w_rem_b  = w_ge1 ? (w_rem1 - w_tr1) : w_rem1;
        w_root_b = {w_root_a[RTW-2:0], w_ge1};
    end

    // One CORDIC rotation per cycle; arithmetic shifts round toward minus infinity.
    assign w_xs   = r_cx >>> r_cnt;
    assign w_ys   = r_cy >>> r_cnt;
    assign w_atan = atan_entry(r_cnt);

    // Denominator of the attenuation from the finished root.
    assign w_den = r_root + DEN_BIAS;

    // Two quotient bits per cycle.
    always_comb begin
        w_dt0    = {r_drem, r_dlow[QW-1]};
        w_dge0   = (w_dt0 >= {1'b0, r_den});
        w_drem_a = w_dge0 ? RTW'(w_dt0 - {1'b0, r_den}) : RTW'(w_dt0);
        w_dt1    = {w_drem_a, r_dlow[QW-2]};
        w_dge1   = (w_dt1 >= {1'b0, r_den});
        w_drem_b = w_dge1 ? RTW'(w_dt1 - {1'b0, r_den}) : RTW'(w_dt1);
    end

    // Level difference from the angle and the special quadrants.
    always_comb begin
        if (r_dz_pos) begin
            if (r_cz > LD_POS) begin
                w_ld = LD_POS;
            end else if (r_cz < LD_NEG) begin
                w_ld = LD_NEG;
            end else begin
                w_ld = r_cz;
            end
        end else if (r_dz_zero && r_dx_zero) begin
            w_ld = '0;
        end else begin
            w_ld = r_dx_neg ? LD_NEG : LD_POS;
        end
    end

    // Attenuation and side gains.
    always_comb begin
        w_att   = r_sat ? GAIN_ONE : r_quo;
        w_lside = r_ld[LW-1] ? GAIN_ONE : GW'(GAIN_ONE - unsigned'(r_ld));
        w_rside = r_ld[LW-1] ? GW'(GAIN_ONE + unsigned'(r_ld)) : GAIN_ONE;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_ROOT;
                    n_cnt   = '0;
                end
            end
            ST_ROOT: begin
                if (r_cnt == CNTW'(CORDIC_STEPS - 1)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end
            ST_DIV: begin
                if (r_cnt == CNTW'(DIV_CYCLES - 1)) begin
                    n_state = ST_GAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end
            ST_GAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_in_range <= i_job.in_range;
                    r_vol      <= i_job.volume;
                    r_num      <= w_num;
                    r_dz_pos   <= !i_job.dz[DW-1] && (i_job.dz != '0);
                    r_dz_zero  <= (i_job.dz == '0);
                    r_dx_neg   <= i_job.dx[DW-1];
                    r_dx_zero  <= (i_job.dx == '0);
                    r_rad      <= {{(2*RTW-SW){1'b0}}, i_job.sum_sq};
                    r_rrem     <= '0;
                    r_root     <= '0;
                    r_cx       <= XW'(i_job.dz);
                    r_cy       <= XW'(i_job.dx);
                    r_cz       <= '0;
                end
            end
            ST_ROOT: begin
                if (r_cnt < CNTW'(ROOT_CYCLES)) begin
                    r_rrem <= w_rem_b;
                    r_root <= w_root_b;
                    r_rad  <= {r_rad[2*RTW-5:0], 4'd0};
                end
                if (!r_cy[XW-1]) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_atan;
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_atan;
                end
                // The root is final in the last step: set up the divide.
                if (r_cnt == CNTW'(CORDIC_STEPS - 1)) begin
                    r_den  <= w_den;
                    r_sat  <= ({{(RTW+QW-1-NW){1'b0}}, r_num} >= {w_den, {(QW-1){1'b0}}});
                    r_aud  <= r_in_range
                           && ({4'd0, {7'd0, r_vol} * AUD_SCALE} > {w_den, 1'b0});
                    r_drem <= RTW'(r_num[NW-1:QW]);
                    r_dlow <= r_num[QW-1:0];
                    r_quo  <= '0;
                end
            end
            ST_DIV: begin
                r_drem <= w_drem_b;
                r_dlow <= {r_dlow[QW-3:0], 2'b00};
                r_quo  <= {r_quo[QW-3:0], w_dge0, w_dge1};
                r_ld   <= w_ld;
            end
            ST_GAIN: begin
                r_lprod <= w_att * w_lside;
                r_rprod <= w_att * w_rside;
            end
            default: begin
            end
        endcase
    end

    // Output register: a finished result waits here while the next source runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_aud   <= r_aud;
            r_out_left  <= r_aud ? r_lprod[2*GW-2 -: GW] : '0;
            r_out_right <= r_aud ? r_rprod[2*GW-2 -: GW] : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_gain  = r_out_left;
    assign o_right_gain = r_out_right;
    assign o_audible    = r_out_aud;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_aud) |-> (r_out_left == '0 && r_out_right == '0))
        else $error("inaudible source with nonzero gain");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_left <= GAIN_ONE && r_out_right <= GAIN_ONE))
        else $error("gain above unity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_ROOT && r_cnt == '0))
        else $error("pop did not start a job");

endmodule
`default_nettype wire

### verif/spatial_source_gain_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spatial_source_gain_test
// Self-checking bench for the spatial source gain block. A driver feeds source
// transactions from a queue, a behavioral predictor computes the gains at
// acceptance, and a monitor compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module spatial_source_gain_test;

    import ssg_pkg::*;

    localparam logic [IW-1:0] REG_UNMAPPED = 2'd3;
    localparam int            DRAIN_CYCLES = 40;
    localparam int            HOLD_CYCLES  = 400;
    localparam longint        CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] sz;
        logic [VW-1:0] volume;
        logic [MW-1:0] max_dist;
    } t_source;

    typedef struct {
        logic [GW-1:0] left;
        logic [GW-1:0] right;
        logic          audible;
    } t_gains;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    logic [CW-1:0]  i_source_x;
    logic [CW-1:0]  i_source_y;
    logic [CW-1:0]  i_source_z;
    logic [VW-1:0]  i_source_volume;
    logic [MW-1:0]  i_max_distance;
    logic           o_valid;
    logic           i_stall;
    logic [GW-1:0]  o_left_gain;
    logic [GW-1:0]  o_right_gain;
    logic           o_audible;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [IW-1:0]  i_cfg_index;
    logic [CW-1:0]  i_cfg_data;

    t_source        pending_sources[$];
    t_gains         expected_gains[$];
    longint         listener_pos[3];
    int             send_idle_pct;
    int             recv_idle_pct;
    logic           hold_armed;
    logic           hold_used;
    int             hold_left;
    int             errors;
    int             results_seen;
    int             audible_seen;
    longint         cycle_count;

    spatial_source_gain u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_source_x      (i_source_x),
        .i_source_y      (i_source_y),
        .i_source_z      (i_source_z),
        .i_source_volume (i_source_volume),
        .i_max_distance  (i_max_distance),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_left_gain     (o_left_gain),
        .o_right_gain    (o_right_gain),
        .o_audible       (o_audible),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor of the square root of a 64-bit value, two bits per step.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe >>= 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Azimuth as a level difference in Q1.15, clamped to half scale.
    function automatic longint azimuth_level(input longint dx, input longint dz);
        longint angle_step[14];
        longint vx;
        longint vy;
        longint ang;
        longint xs;
        longint ys;
        angle_step = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        if (dz <= 0) begin
            if (dx == 0 && dz == 0) return 0;
            return (dx < 0) ? -16384 : 16384;
        end
        vx  = dz;
        vy  = dx;
        ang = 0;
        for (int i = 0; i < 14; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + ys;
                vy  = vy - xs;
                ang = ang + angle_step[i];
            end else begin
                vx  = vx - ys;
                vy  = vy + xs;
                ang = ang - angle_step[i];
            end
        end
        if (ang > 16384) ang = 16384;
        if (ang < -16384) ang = -16384;
        return ang;
    endfunction

    // Gains of one source seen from the current listener position.
    function automatic t_gains source_gains(input t_source src);
        t_gains          g;
        longint          dx;
        longint          dy;
        longint          dz;
        longint unsigned sum_sq;
        longint unsigned range_q8;
        longint unsigned maxd;
        longint unsigned att;
        longint          lvl;
        longint unsigned lside;
        longint unsigned rside;
        dx       = longint'(signed'(src.sx)) - listener_pos[0];
        dy       = longint'(signed'(src.sy)) - listener_pos[1];
        dz       = longint'(signed'(src.sz)) - listener_pos[2];
        sum_sq   = dx * dx + dy * dy + dz * dz;
        range_q8 = floor_sqrt(sum_sq);
        maxd     = src.max_dist;
        g        = '{default: '0};
        if (sum_sq < maxd * maxd && 125 * longint'(src.volume) > 2 * (2560 + range_q8)) begin
            att = longint'(src.volume) * 20480 / (2560 + range_q8);
            if (att > 32768) att = 32768;
            lvl       = azimuth_level(dx, dz);
            lside     = 32768 - ((lvl > 0) ? lvl : 0);
            rside     = 32768 + ((lvl < 0) ? lvl : 0);
            g.left    = GW'((att * lside) >> 15);
            g.right   = GW'((att * rside) >> 15);
            g.audible = 1'b1;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Source driver: holds a stalled transaction, otherwise offers the next one.
    always @(posedge i_clk) begin
        t_source nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_sources.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt              = pending_sources.pop_front();
                i_source_x      <= nxt.sx;
                i_source_y      <= nxt.sy;
                i_source_z      <= nxt.sz;
                i_source_volume <= nxt.volume;
                i_max_distance  <= nxt.max_dist;
                i_valid         <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Prediction at acceptance of each source transaction.
    always @(posedge i_clk) begin
        t_source acc;
        if (i_rst_n && i_valid && !o_stall) begin
            acc = '{i_source_x, i_source_y, i_source_z, i_source_volume, i_max_distance};
            expected_gains = {expected_gains, source_gains(acc)};
        end
    end

    // Long receiver hold-off, counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_armed && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_gains want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_audible) audible_seen++;
            if (expected_gains.size() == 0) begin
                $display("[%0t] result with nothing expected", $time);
                errors++;
            end else begin
                want = expected_gains.pop_front();
                if (o_left_gain !== want.left) report_mismatch("left_gain", o_left_gain, want.left);
                if (o_right_gain !== want.right)
                    report_mismatch("right_gain", o_right_gain, want.right);
                if (o_audible !== want.audible)
                    report_mismatch("audible", o_audible, want.audible);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_source(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                              input logic [CW-1:0] sz, input logic [VW-1:0] vol,
                              input logic [MW-1:0] maxd);
        t_source src;
        src             = '{sx, sy, sz, vol, maxd};
        pending_sources = {pending_sources, src};
    endtask

    // Random source: each coordinate mostly near the listener so that it is audible.
    task automatic add_random_source();
        int            span;
        logic [CW-1:0] pos[3];
        span = $urandom_range(6, 20);
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(99) < 25) pos[k] = CW'($urandom);
            else pos[k] = CW'(listener_pos[k] + $signed($urandom_range(2 * (1 << span)))
                              - (1 << span));
        end
        add_source(pos[0], pos[1], pos[2], VW'($urandom),
                   ($urandom_range(9) == 0) ? MW'($urandom_range(3)) : MW'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_sources.size() > 0 || i_valid || expected_gains.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the channel idles before the next one.
    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx != REG_UNMAPPED) listener_pos[idx] = longint'(signed'(val));
        @(posedge i_clk);
    endtask

    task automatic set_listener(input logic [CW-1:0] lx, input logic [CW-1:0] ly,
                                input logic [CW-1:0] lz);
        write_reg(REG_LISTENER_X, lx);
        write_reg(REG_LISTENER_Y, ly);
        write_reg(REG_LISTENER_Z, lz);
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_source_x      = '0;
        i_source_y      = '0;
        i_source_z      = '0;
        i_source_volume = '0;
        i_max_distance  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        hold_armed      = 1'b0;
        errors          = 0;
        results_seen    = 0;
        audible_seen    = 0;
        cycle_count     = 0;
        listener_pos    = '{0, 0, 0};
        send_idle_pct   = 38;
        recv_idle_pct   = 87;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: listener at origin, each azimuth branch and the edges.
        add_source(24'd0, 24'd0, 24'd0, 16'hFFFF, 24'hFFFFFF);      // co-located
        add_source(24'd512, 24'd0, 24'd0, 16'd4096, 24'hFFFFFF);    // right, dz zero
        add_source(-24'sd512, 24'd0, 24'd0, 16'd4096, 24'hFFFFFF); // left, dz zero
        add_source(24'd256, 24'd0, -24'sd256, 16'd8192, 24'hFFFFFF); // behind right
        add_source(-24'sd256, 24'd0, -24'sd256, 16'd8192, 24'hFFFFFF);
        add_source(24'd0, 24'd0, -24'sd1024, 16'd8192, 24'hFFFFFF); // straight behind
        add_source(24'd0, 24'd0, 24'd1024, 16'd8192, 24'hFFFFFF);   // straight ahead
        add_source(24'd700, 24'd300, 24'd900, 16'd12000, 24'hFFFFFF);
        add_source(-24'sd700, -24'sd300, 24'd900, 16'd12000, 24'hFFFFFF);
        add_source(24'd100, 24'd100, 24'd100, 16'hFFFF, 24'd0);     // zero range
        add_source(24'd100, 24'd100, 24'd100, 16'd0, 24'hFFFFFF);   // silent
        add_source(24'd100, 24'd0, 24'd100, 16'd42, 24'hFFFFFF);    // near threshold
        add_source(24'd0, 24'd0, 24'd256, 16'd4096, 24'd256);       // exactly at range
        add_source(24'd0, 24'd0, 24'd255, 16'd4096, 24'd256);       // just inside
        add_source(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 24'hFFFFFF);
        add_source(24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 24'hFFFFFF);
        add_source(24'hFFFFFF, 24'h000001, 24'h000001, 16'hFFFF, 24'hFFFFFF);
        wait_idle();

        // Listener at the extremes, plus a write to an unmapped index.
        set_listener(24'h800000, 24'h7FFFFF, 24'h800000);
        write_reg(REG_UNMAPPED, 24'h123456);
        add_source(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 24'hFFFFFF);
        add_source(24'h800000, 24'h7FFFFF, 24'h800001, 16'hFFFF, 24'hFFFFFF);
        add_source(24'h800100, 24'h7FFFFF, 24'h800000, 16'hFFFF, 24'hFFFFFF);
        for (int n = 0; n < 250; n++) add_random_source();
        wait_idle();

        // Swap idling, random listener.
        send_idle_pct = 87;
        recv_idle_pct = 38;
        set_listener(CW'($urandom), CW'($urandom), CW'($urandom));
        for (int n = 0; n < 250; n++) add_random_source();
        wait_idle();

        // No idling; a long receiver hold-off fills the block.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_listener(24'h7FFFFF, 24'h000000, 24'h7FFFFF);
        hold_armed = 1'b1;
        for (int n = 0; n < 250; n++) add_random_source();
        wait_idle();

        $display("checked %0d results, %0d audible, over four listener positions",
                 results_seen, audible_seen);
        $display("sender/receiver idling swapped between phases, one long hold-off");
        if (errors == 0 && expected_gains.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results outstanding", errors, expected_gains.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
design/ssg_pkg.sv
design/ssg_front.sv
design/ssg_queue.sv
design/ssg_back.sv
design/spatial_source_gain.sv
verif/spatial_source_gain_test.sv
